// ===== sv/csmm_pkg.sv =====
// Shared widths and reset constants for the carry-save Montgomery multiplier.
package csmm_pkg;

	localparam int WIDTH_DEF = 16;
	localparam int OPND_W    = 15;
	localparam int MOD_W     = 15;
	localparam int PROD_W    = 16;

	localparam logic [MOD_W-1:0] MOD_RESET = 15'd3329;

endpackage

// ===== sv/carry_save_montgomery_multiplier_core.sv =====
// Top level: modulus register, chain of Montgomery bit cells, final reduction.
// Pipeline: one cell per multiplicand bit, then a resolve stage and a subtract
//   stage.
// Throughput: one word per cycle; busy stays low, the chain takes a new word every cycle.
// Reset: arst_n clears all valid flags and loads the modulus with 3329.
// The result strobe done lasts one cycle; the receiver cannot stall the chain.
module carry_save_montgomery_multiplier_core #(
	parameter int WIDTH = csmm_pkg::WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [csmm_pkg::OPND_W-1:0]   multiplicand,
	input  logic [csmm_pkg::OPND_W-1:0]   multiplier,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [csmm_pkg::MOD_W-1:0]    cfg_data,
	output logic                          done,
	output logic [csmm_pkg::PROD_W-1:0]   product
);

	localparam int SW  = (WIDTH > csmm_pkg::OPND_W) ? WIDTH : csmm_pkg::OPND_W;
	localparam int LAT = WIDTH + 2;

	logic [csmm_pkg::MOD_W-1:0] mod_q;

	logic                        vld_c   [0:WIDTH];
	logic [WIDTH-1:0]            a_c     [0:WIDTH];
	logic [csmm_pkg::OPND_W-1:0] b_c     [0:WIDTH];
	logic [SW-1:0]               sum_c   [0:WIDTH];
	logic [SW-1:0]               carry_c [0:WIDTH];
	logic [SW-1:0]               a_ext;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q <= csmm_pkg::MOD_RESET;
		end else if (cfg_valid && cfg_ready) begin
			mod_q <= cfg_data;
		end
	end

	assign a_ext      = SW'(multiplicand);
	assign vld_c[0]   = start && !busy;
	assign a_c[0]     = a_ext[WIDTH-1:0];
	assign b_c[0]     = multiplier;
	assign sum_c[0]   = '0;
	assign carry_c[0] = '0;

	for (genvar i = 0; i < WIDTH; i++) begin : g_cell
		csmm_cell #(
			.WIDTH (WIDTH),
			.SW    (SW),
			.BIT   (i)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.vld_i   (vld_c[i]),
			.a_i     (a_c[i]),
			.b_i     (b_c[i]),
			.sum_i   (sum_c[i]),
			.carry_i (carry_c[i]),
			.mod_i   (mod_q),
			.vld_o   (vld_c[i+1]),
			.a_o     (a_c[i+1]),
			.b_o     (b_c[i+1]),
			.sum_o   (sum_c[i+1]),
			.carry_o (carry_c[i+1])
		);
	end

	csmm_final #(
		.SW (SW)
	) u_final (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld_i   (vld_c[WIDTH]),
		.sum_i   (sum_c[WIDTH]),
		.carry_i (carry_c[WIDTH]),
		.mod_i   (mod_q),
		.done    (done),
		.product (product)
	);

	// every result traces back to an earlier accepted word
	a_done_from_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("done without matching start");

	// reduced operands under an odd modulus give a fully reduced product
	a_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (WIDTH >= 16) && mod_q[0] && (mod_q >= 3)
			&& ($past(mod_q, LAT) == mod_q)
			&& ($past(multiplicand, LAT) < mod_q)
			&& ($past(multiplier, LAT) < mod_q))
		|-> (product < csmm_pkg::PROD_W'(mod_q)))
		else $error("product not reduced");

endmodule

// ===== sv/csmm_cell.sv =====
// One bit step of the Montgomery chain: conditional add, odd fix-up, halve.
module csmm_cell #(
	parameter int WIDTH = csmm_pkg::WIDTH_DEF,
	parameter int SW    = csmm_pkg::OPND_W,
	parameter int BIT   = 0
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          vld_i,
	input  logic [WIDTH-1:0]              a_i,
	input  logic [csmm_pkg::OPND_W-1:0]   b_i,
	input  logic [SW-1:0]                 sum_i,
	input  logic [SW-1:0]                 carry_i,
	input  logic [csmm_pkg::MOD_W-1:0]    mod_i,
	output logic                          vld_o,
	output logic [WIDTH-1:0]              a_o,
	output logic [csmm_pkg::OPND_W-1:0]   b_o,
	output logic [SW-1:0]                 sum_o,
	output logic [SW-1:0]                 carry_o
);

	localparam logic [SW:0]   ONE_W = (SW+1)'(1) << WIDTH;
	localparam logic [SW-1:0] WMASK = SW'(ONE_W - (SW+1)'(1));

	logic [SW-1:0] b_ext;
	logic [SW-1:0] m_ext;
	logic [SW-1:0] cs;
	logic [SW-1:0] sx;
	logic [SW-1:0] s1;
	logic [SW-1:0] c1;
	logic [SW-1:0] addend;
	logic [SW-1:0] g;
	logic [SW-1:0] x;
	logic [SW-1:0] h;
	logic [SW-1:0] sum_n;
	logic [SW-1:0] carry_n;

	logic                        vld_q;
	logic [WIDTH-1:0]            a_q;
	logic [csmm_pkg::OPND_W-1:0] b_q;
	logic [SW-1:0]               sum_q;
	logic [SW-1:0]               carry_q;

	always_comb begin
		b_ext = SW'(b_i);
		m_ext = SW'(mod_i);
		cs    = {carry_i[SW-2:0], 1'b0} & WMASK;
		sx    = sum_i ^ b_ext;
		if (a_i[BIT]) begin
			s1 = cs ^ sx;
			c1 = (sum_i & b_ext) | (cs & sx);
		end else begin
			s1 = sum_i;
			c1 = carry_i;
		end
		addend  = s1[0] ? m_ext : '0;
		g       = s1 & addend;
		x       = ((s1 ^ addend) & WMASK) >> 1;
		h       = x ^ g;
		sum_n   = c1 ^ h;
		carry_n = (x & g) | (c1 & h);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		a_q     <= a_i;
		b_q     <= b_i;
		sum_q   <= sum_n;
		carry_q <= carry_n;
	end

	assign vld_o   = vld_q;
	assign a_o     = a_q;
	assign b_o     = b_q;
	assign sum_o   = sum_q;
	assign carry_o = carry_q;

endmodule

// ===== sv/csmm_final.sv =====
// Resolves the carry-save pair and applies the single modulus subtraction.
module csmm_final #(
	parameter int SW = csmm_pkg::OPND_W
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          vld_i,
	input  logic [SW-1:0]                 sum_i,
	input  logic [SW-1:0]                 carry_i,
	input  logic [csmm_pkg::MOD_W-1:0]    mod_i,
	output logic                          done,
	output logic [csmm_pkg::PROD_W-1:0]   product
);

	localparam int PW = SW + 2;

	logic          vld_s1;
	logic [PW-1:0] p_s1;
	logic          vld_s2;
	logic [PW-1:0] p_red;
	logic [csmm_pkg::PROD_W-1:0] product_s2;

	always_comb begin
		if (p_s1 >= PW'(mod_i)) begin
			p_red = p_s1 - PW'(mod_i);
		end else begin
			p_red = p_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= vld_i;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		p_s1       <= {1'b0, carry_i, 1'b0} + PW'(sum_i);
		product_s2 <= p_red[csmm_pkg::PROD_W-1:0];
	end

	assign done    = vld_s2;
	assign product = product_s2;

endmodule
